/* hdl/alcd_pkg.sv */
// Shared constants, register indexes and types for the ambient light change detector.
`default_nettype none

package alcd_pkg;

    // Fixed field widths
    localparam int TIME_BITS     = 32;
    localparam int THR_BITS      = 7;
    localparam int COOL_BITS     = 16;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 16;

    // Scale factors of the change test: |avg - applied| * 100 >= thr * (applied + 1.0 lux)
    localparam int                PCT_BITS      = 7;
    localparam logic [PCT_BITS-1:0] PERCENT_SCALE = 7'd100;
    localparam int                LUX_ONE       = 16;

    // Register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_COOLDOWN  = 1'b1;

    // Register reset values
    localparam logic [THR_BITS-1:0]  THRESHOLD_RESET = 7'd10;
    localparam logic [COOL_BITS-1:0] COOLDOWN_RESET  = 16'd500;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage

`default_nettype wire

/* hdl/alcd_serial_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module alcd_serial_div #(
    parameter int DIVIDEND_BITS = 24,
    parameter int DIVISOR_BITS  = 4
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output logic      [DIVIDEND_BITS-1:0] quotient,
    output logic                          done
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] dvd_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  dsr_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic                     run_reg;
    logic                     done_reg;

    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     ge;

    // shift next dividend bit into the partial remainder
    assign trial = {rem_reg, dvd_reg[DIVIDEND_BITS-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_BITS'(DIVIDEND_BITS);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (run_reg) begin
            // quotient bits fill the dividend register from the bottom
            dvd_reg <= {dvd_reg[DIVIDEND_BITS-2:0], ge};
            rem_reg <= ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

/* hdl/alcd_serial_cmp.sv */
// Shift-add unit deciding diff * 100 >= thr * base, one multiplier bit per cycle.
`default_nettype none

module alcd_serial_cmp #(
    parameter int LUX_BITS = 20
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [LUX_BITS-1:0]           diff,
    input  wire logic [LUX_BITS:0]             base,
    input  wire logic [alcd_pkg::THR_BITS-1:0] thr,
    output logic                               ge,
    output logic                               done
);

    localparam int ACC_BITS = LUX_BITS + 9;
    localparam int PCT_BITS = alcd_pkg::PCT_BITS;
    localparam int CNT_BITS = $clog2(PCT_BITS + 1);

    logic [ACC_BITS-1:0] acc_reg;
    logic [ACC_BITS-1:0] acc_next;
    logic [ACC_BITS-1:0] dsh_reg;
    logic [ACC_BITS-1:0] bsh_reg;
    logic [PCT_BITS-1:0] ksh_reg;
    logic [PCT_BITS-1:0] tsh_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                run_reg;
    logic                done_reg;

    // two's complement accumulator of diff*100 - thr*base
    assign acc_next = acc_reg + (ksh_reg[0] ? dsh_reg : '0) - (tsh_reg[0] ? bsh_reg : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_BITS'(PCT_BITS);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            dsh_reg <= ACC_BITS'(diff);
            bsh_reg <= ACC_BITS'(base);
            ksh_reg <= alcd_pkg::PERCENT_SCALE;
            tsh_reg <= thr;
        end else if (run_reg) begin
            acc_reg <= acc_next;
            dsh_reg <= {dsh_reg[ACC_BITS-2:0], 1'b0};
            bsh_reg <= {bsh_reg[ACC_BITS-2:0], 1'b0};
            ksh_reg <= {1'b0, ksh_reg[PCT_BITS-1:1]};
            tsh_reg <= {1'b0, tsh_reg[PCT_BITS-1:1]};
        end
    end

    assign ge   = !acc_reg[ACC_BITS-1];
    assign done = done_reg;

endmodule

`default_nettype wire

/* hdl/ambient_light_change_detector_unit.sv */
// Top level of the ambient light change detector: sample window, serial mean and change test.
//
//  Channel | Dir | Handshake          | Content
//  --------+-----+--------------------+------------------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: sample_lux, now_ms; tuser: sample_valid, busy
//  m_      | out | m_tvalid/m_tready  | tdata: average_lux; tuser: apply_update, deferred
//  cfg_    | in  | cfg_we             | cfg_addr 0 threshold_percent, 1 cooldown_ms
//
// One transaction in gives one transaction out. From acceptance to a loaded
// result, a valid read passes through the bit-serial mean divider and the
// 7-step shift-add test; an invalid read skips the test and goes from the
// divider straight to the output register.
// A finished result sits in the output register, so the next item is taken
// while it waits; a stalled m_tready holds the sequencer only once a second
// result is ready. Reset is synchronous, active low; no clearing pass.
`default_nettype none

module ambient_light_change_detector_unit #(
    parameter int WINDOW   = 10,
    parameter int LUX_BITS = 20,
    localparam int IN_DATA_BITS  = ((LUX_BITS + alcd_pkg::TIME_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_BITS = ((LUX_BITS + 7) / 8) * 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // sample channel
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [IN_DATA_BITS-1:0]             s_tdata,  // sample_lux, now_ms, zero pad
    input  wire logic [1:0]                          s_tuser,  // sample_valid, transition_busy
    // result channel
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [OUT_DATA_BITS-1:0]            m_tdata,  // average_lux, zero pad
    output logic      [1:0]                          m_tuser,  // apply_update, update_deferred
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [alcd_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [alcd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int TIME_BITS = alcd_pkg::TIME_BITS;
    localparam int CNT_BITS  = $clog2(WINDOW + 1);
    localparam int SUM_BITS  = LUX_BITS + $clog2(WINDOW);
    localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // configuration registers
    logic [alcd_pkg::THR_BITS-1:0]  thr_reg;
    logic [alcd_pkg::COOL_BITS-1:0] cool_reg;

    // sequencer
    alcd_pkg::state_t state_reg, state_next;
    logic             div_start_reg;
    logic             cmp_start_reg;

    // latched item
    logic                 item_valid_reg;
    logic                 item_busy_reg;
    logic [TIME_BITS-1:0] now_reg;

    // window state
    logic [LUX_BITS-1:0]  ring_reg [WINDOW];
    logic [SUM_BITS-1:0]  sum_reg;
    logic [SUM_BITS-1:0]  sum_next;
    logic [CNT_BITS-1:0]  count_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [LUX_BITS-1:0]  applied_lux_reg;
    logic [TIME_BITS-1:0] applied_time_reg;

    // working result
    logic [LUX_BITS-1:0]  avg_reg;
    logic                 res_apply_reg;
    logic                 res_defer_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [LUX_BITS-1:0]  out_avg_reg;
    logic                 out_apply_reg;
    logic                 out_defer_reg;

    logic                 accept;
    logic                 out_load;
    logic                 full;
    logic [LUX_BITS-1:0]  lux_in;
    logic [LUX_BITS-1:0]  leaving;
    logic [SUM_BITS-1:0]  div_quot;
    logic                 div_done;
    logic [LUX_BITS-1:0]  avg_calc;
    logic [LUX_BITS-1:0]  diff;
    logic [LUX_BITS:0]    base;
    logic                 cmp_ge;
    logic                 cmp_done;
    logic [TIME_BITS-1:0] elapsed;
    logic                 qualifies;

    assign s_tready = (state_reg == alcd_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == alcd_pkg::S_DONE) && (!m_tvalid_reg || m_tready);

    assign lux_in  = s_tdata[LUX_BITS-1:0];
    assign full    = (count_reg == CNT_BITS'(WINDOW));
    // oldest sample drops out once the window is full
    assign leaving = full ? ring_reg[slot_reg] : '0;
    assign sum_next = sum_reg - SUM_BITS'(leaving) + SUM_BITS'(lux_in);

    // mean of an empty window is zero
    assign avg_calc = (count_reg == '0) ? '0 : div_quot[LUX_BITS-1:0];

    // change test operands
    assign diff = (avg_reg >= applied_lux_reg) ? (avg_reg - applied_lux_reg)
                                               : (applied_lux_reg - avg_reg);
    assign base = {1'b0, applied_lux_reg} + (LUX_BITS + 1)'(alcd_pkg::LUX_ONE);

    // elapsed time wraps modulo 2^32
    assign elapsed   = now_reg - applied_time_reg;
    assign qualifies = cmp_ge && (elapsed >= TIME_BITS'(cool_reg));

    alcd_serial_div #(
        .DIVIDEND_BITS (SUM_BITS),
        .DIVISOR_BITS  (CNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .quotient (div_quot),
        .done     (div_done)
    );

    alcd_serial_cmp #(
        .LUX_BITS (LUX_BITS)
    ) u_cmp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmp_start_reg),
        .diff    (diff),
        .base    (base),
        .thr     (thr_reg),
        .ge      (cmp_ge),
        .done    (cmp_done)
    );

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            alcd_pkg::S_IDLE: begin
                if (accept) state_next = alcd_pkg::S_DIV;
            end
            alcd_pkg::S_DIV: begin
                if (div_done) state_next = item_valid_reg ? alcd_pkg::S_MUL : alcd_pkg::S_DONE;
            end
            alcd_pkg::S_MUL: begin
                if (cmp_done) state_next = alcd_pkg::S_DONE;
            end
            alcd_pkg::S_DONE: begin
                if (out_load) state_next = alcd_pkg::S_IDLE;
            end
            default: state_next = alcd_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= alcd_pkg::S_IDLE;
            div_start_reg    <= 1'b0;
            cmp_start_reg    <= 1'b0;
            thr_reg          <= alcd_pkg::THRESHOLD_RESET;
            cool_reg         <= alcd_pkg::COOLDOWN_RESET;
            sum_reg          <= '0;
            count_reg        <= '0;
            slot_reg         <= '0;
            applied_lux_reg  <= '0;
            applied_time_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= accept;
            cmp_start_reg <= div_done && item_valid_reg;

            if (cfg_we) begin
                unique case (cfg_addr)
                    alcd_pkg::REG_THRESHOLD: thr_reg  <= cfg_wdata[alcd_pkg::THR_BITS-1:0];
                    alcd_pkg::REG_COOLDOWN:  cool_reg <= cfg_wdata[alcd_pkg::COOL_BITS-1:0];
                    default: ;
                endcase
            end

            // window update for a good read
            if (accept && s_tuser[0]) begin
                sum_reg  <= sum_next;
                if (!full) count_reg <= count_reg + 1'b1;
                slot_reg <= (slot_reg == SLOT_BITS'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end

            if (cmp_done && qualifies && !item_busy_reg) begin
                applied_lux_reg  <= avg_reg;
                applied_time_reg <= now_reg;
            end

            if (out_load) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_valid_reg <= s_tuser[0];
            item_busy_reg  <= s_tuser[1];
            now_reg        <= s_tdata[LUX_BITS +: TIME_BITS];
            if (s_tuser[0]) ring_reg[slot_reg] <= lux_in;
        end
        if (div_done) begin
            avg_reg       <= avg_calc;
            res_apply_reg <= 1'b0;
            res_defer_reg <= 1'b0;
        end
        if (cmp_done) begin
            res_apply_reg <= qualifies && !item_busy_reg;
            res_defer_reg <= qualifies && item_busy_reg;
        end
        if (out_load) begin
            out_avg_reg   <= avg_reg;
            out_apply_reg <= res_apply_reg;
            out_defer_reg <= res_defer_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_BITS'(out_avg_reg);
    assign m_tuser  = {out_defer_reg, out_apply_reg};

`ifndef SYNTHESIS
    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == alcd_pkg::S_DIV))
        else $error("accepted transaction did not start the divider");

    a_no_apply_and_defer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("update both applied and deferred");

    a_invalid_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == alcd_pkg::S_DONE) && !item_valid_reg)
            |-> !(res_apply_reg || res_defer_reg))
        else $error("invalid read raised an update flag");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CNT_BITS'(WINDOW)))
        else $error("stored count exceeds window");
`endif

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the ambient light change detector: windowed mean and change test.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW     = 10;
    localparam int LUX_W      = 20;
    localparam int IN_W       = 56;     // sample_lux + now_ms, padded to bytes
    localparam int OUT_W      = 24;     // average_lux, padded to bytes
    localparam int LAT_CYCLES = 40;     // longer than the item latency
    localparam int LONG_HOLD  = 800;    // receiver hold-off, far beyond two item times
    localparam int MAX_CYCLES = 1_000_000;
    localparam logic [LUX_W-1:0] LUX_MAX = '1;

    // one sample transaction, as it goes into the block
    typedef struct packed {
        logic [LUX_W-1:0] lux;
        logic             valid;
        logic [31:0]      now;
        logic             busy;
    } light_sample_t;

    // one result transaction, as it leaves the block
    typedef struct packed {
        logic [LUX_W-1:0] level;
        logic             apply;
        logic             deferred;
    } level_result_t;

    // receiver stall styles, switched at random
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } rx_style_t;

    // clock, reset and every block input start at a known value
    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [IN_W-1:0]          s_tdata   = '0;   // [19:0] sample_lux, [51:20] now_ms, zero pad
    logic [1:0]               s_tuser   = '0;   // [0] sample_valid, [1] transition_busy
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_W-1:0]         m_tdata;          // [19:0] average_lux, zero pad
    logic [1:0]               m_tuser;          // [0] apply_update, [1] update_deferred
    logic                     cfg_we    = 1'b0;
    logic [alcd_pkg::CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [alcd_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

    always #2 aclk = ~aclk;

    ambient_light_change_detector_unit #(
        .WINDOW   (WINDOW),
        .LUX_BITS (LUX_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: sample window, running sum, last applied level.
    // Reset happens once at time zero, so the declarations carry it.
    // ------------------------------------------------------------------
    logic [LUX_W-1:0]   ring_lux [WINDOW];
    logic [23:0]        ring_sum      = '0;
    logic [3:0]         ring_slot     = '0;
    logic [3:0]         ring_fill     = '0;
    logic [LUX_W-1:0]   applied_level = '0;
    logic [31:0]        applied_ms    = '0;
    logic [alcd_pkg::THR_BITS-1:0]  thr_pct = alcd_pkg::THRESHOLD_RESET;
    logic [alcd_pkg::COOL_BITS-1:0] cool_ms = alcd_pkg::COOLDOWN_RESET;

    light_sample_t pending_samples [$];   // waiting for the sender
    level_result_t expected_levels [$];   // predicted, not yet seen on m_

    int mismatch_count = 0;
    int cycle_count    = 0;

    // sender burst/gap bookkeeping
    light_sample_t offered;
    int burst_left = 0;
    int gap_left   = 0;

    // receiver state
    rx_style_t  rx_style     = RX_ALWAYS;
    int         rx_style_left = 0;
    logic [7:0] rx_pattern   = 8'h5b;
    int         hold_left    = 0;
    int         long_holds_asked = 0;
    int         long_holds_begun = 0;

    // stimulus generator state: time base and a drifting light level
    logic [31:0]      gen_ms    = '0;
    logic [LUX_W-1:0] gen_level = 20'h00640;

    // Window update plus change test for one accepted sample.
    function automatic level_result_t predict_level(input light_sample_t smp);
        level_result_t res;
        logic [LUX_W-1:0] diff;
        logic [63:0]      lhs;
        logic [63:0]      rhs;
        logic [31:0]      elapsed;
        res = '0;
        if (smp.valid) begin
            // oldest sample drops out once the window is full
            if (ring_fill == 4'(WINDOW))
                ring_sum = ring_sum - 24'(ring_lux[ring_slot]);
            else
                ring_fill = ring_fill + 4'd1;
            ring_lux[ring_slot] = smp.lux;
            ring_sum  = ring_sum + 24'(smp.lux);
            ring_slot = (ring_slot == 4'(WINDOW - 1)) ? 4'd0 : ring_slot + 4'd1;
        end
        // divide by what is actually stored, zero when nothing is
        res.level = (ring_fill == 4'd0) ? '0 : LUX_W'(ring_sum / 24'(ring_fill));
        if (smp.valid) begin
            diff    = (res.level >= applied_level) ? res.level - applied_level
                                                   : applied_level - res.level;
            lhs     = 64'(diff) * 64'(alcd_pkg::PERCENT_SCALE);
            rhs     = 64'(thr_pct) * (64'(applied_level) + 64'(alcd_pkg::LUX_ONE));
            elapsed = smp.now - applied_ms;   // modulo 2^32
            if (lhs >= rhs && elapsed >= 32'(cool_ms)) begin
                if (smp.busy) begin
                    res.deferred = 1'b1;
                end else begin
                    res.apply     = 1'b1;
                    applied_level = res.level;
                    applied_ms    = smp.now;
                end
            end
        end
        return res;
    endfunction

    task automatic queue_sample(input logic [LUX_W-1:0] lux, input logic valid,
                                input logic [31:0] now, input logic busy);
        light_sample_t smp;
        smp.lux   = lux;
        smp.valid = valid;
        smp.now   = now;
        smp.busy  = busy;
        pending_samples.push_back(smp);
    endtask

    // Mostly samples near a drifting level so the threshold is hit at its edge,
    // plus full-range, tiny and near-maximum values; time moves mostly at 10 Hz.
    task automatic queue_random_phase(input int count);
        light_sample_t smp;
        int span;
        int lv;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 15) == 0)
                gen_level = LUX_W'($urandom_range(0, 32'(LUX_MAX)));
            case ($urandom_range(0, 9))
                0:       smp.lux = LUX_W'($urandom());
                1:       smp.lux = LUX_W'($urandom_range(0, 63));
                2:       smp.lux = LUX_MAX - LUX_W'($urandom_range(0, 63));
                default: begin
                    span = int'(gen_level) / 8 + 20;
                    lv   = int'(gen_level) + int'($urandom_range(0, 2 * span)) - span;
                    if (lv < 0)
                        lv = 0;
                    if (lv > int'(LUX_MAX))
                        lv = int'(LUX_MAX);
                    smp.lux = LUX_W'(lv);
                end
            endcase
            case ($urandom_range(0, 9))
                0:       gen_ms = gen_ms + $urandom_range(0, 5);
                7:       gen_ms = gen_ms + $urandom_range(0, 70000);
                8:       gen_ms = gen_ms + 32'(cool_ms) + $urandom_range(0, 4) - 2;
                9:       gen_ms = ($urandom_range(0, 3) == 0) ? $urandom()
                                                               : gen_ms + $urandom_range(500, 3000);
                default: gen_ms = gen_ms + $urandom_range(80, 120);
            endcase
            // now and then park just below the wrap point
            if ($urandom_range(0, 39) == 0)
                gen_ms = 32'hffff_ffff - $urandom_range(0, 300);
            smp.now   = gen_ms;
            smp.valid = ($urandom_range(0, 7) != 0);
            smp.busy  = ($urandom_range(0, 3) == 0);
            pending_samples.push_back(smp);
        end
    endtask

    // Register write; the predictor takes the value at the same moment.
    task automatic write_reg(input logic [alcd_pkg::CFG_ADDR_BITS-1:0] idx,
                             input logic [alcd_pkg::CFG_DATA_BITS-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == alcd_pkg::REG_THRESHOLD)
            thr_pct = val[alcd_pkg::THR_BITS-1:0];
        else
            cool_ms = val[alcd_pkg::COOL_BITS-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [alcd_pkg::THR_BITS-1:0] thr,
                              input logic [alcd_pkg::COOL_BITS-1:0] cool);
        write_reg(alcd_pkg::REG_THRESHOLD, alcd_pkg::CFG_DATA_BITS'(thr));
        write_reg(alcd_pkg::REG_COOLDOWN, cool);
    endtask

    // Sampled on the falling edge, clear of the rising-edge updates.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_levels.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Sender: offers queued samples in bursts with random gaps. A sample
    // accepted at this edge goes through the predictor before the next is
    // put on the bus.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_levels.push_back(predict_level(offered));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    offered = pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, offered.now, offered.lux};
                    s_tuser  <= {offered.busy, offered.valid};
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2:    gap_left = 0;      // back-to-back stretch
                            3, 4, 5, 6: gap_left = $urandom_range(1, 10);
                            default:    gap_left = $urandom_range(11, 80);
                        endcase
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started on request from the stimulus thread.
    always @(posedge aclk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (long_holds_begun < long_holds_asked) begin
            hold_left        <= LONG_HOLD;
            long_holds_begun <= long_holds_begun + 1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stalls in a changing style, checks each result transaction
    // against the oldest prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : rx_side
        level_result_t want;
        level_result_t got;
        logic          rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.level    = m_tdata[LUX_W-1:0];
                got.apply    = m_tuser[0];
                got.deferred = m_tuser[1];
                if (expected_levels.size() == 0) begin
                    mismatch_count++;
                    $display({"%0t: result with none expected: expected none, ",
                              "actual level %h apply %b deferred %b"},
                             $time, got.level, got.apply, got.deferred);
                end else begin
                    want = expected_levels.pop_front();
                    if (got.level !== want.level) begin
                        mismatch_count++;
                        $display("%0t: average_lux expected %h actual %h",
                                 $time, want.level, got.level);
                    end
                    if (got.apply !== want.apply) begin
                        mismatch_count++;
                        $display("%0t: apply_update expected %b actual %b",
                                 $time, want.apply, got.apply);
                    end
                    if (got.deferred !== want.deferred) begin
                        mismatch_count++;
                        $display("%0t: update_deferred expected %b actual %b",
                                 $time, want.deferred, got.deferred);
                    end
                end
            end
            // pick a new stall style when the current one runs out
            if (rx_style_left == 0) begin
                rx_style      = rx_style_t'($urandom_range(0, 3));
                rx_style_left = $urandom_range(64, 512);
                rx_pattern    = 8'($urandom_range(1, 255));
            end else begin
                rx_style_left = rx_style_left - 1;
                rx_pattern    = {rx_pattern[6:0], rx_pattern[7]};
            end
            case (rx_style)
                RX_ALWAYS:  rdy = 1'b1;
                RX_COIN:    rdy = 1'($urandom_range(0, 1));
                RX_PATTERN: rdy = rx_pattern[0];
                default:    rdy = ($urandom_range(0, 3) == 0);
            endcase
            m_tready <= rdy && (hold_left == 0);
        end
    end

    // Watchdog: far above the slowest legal run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus thread: reset, directed samples, then random phases at
    // several register settings, written only while the block is drained.
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset settings: threshold 10 %, cooldown 500 ms
        queue_sample(LUX_MAX, 1'b0, 32'd0, 1'b0);          // invalid with empty window
        queue_sample(20'd1, 1'b1, 32'd1000, 1'b0);         // change just below threshold
        queue_sample(20'd3, 1'b1, 32'd1000, 1'b1);         // qualifies, transition busy
        queue_sample(20'd2, 1'b1, 32'd1000, 1'b0);         // qualifies, applied
        queue_sample(LUX_MAX, 1'b1, 32'd1499, 1'b0);       // one ms short of cooldown
        queue_sample(LUX_MAX, 1'b1, 32'd1500, 1'b0);       // cooldown exactly met
        queue_sample(20'd0, 1'b0, 32'd1500, 1'b1);         // invalid mid-stream
        for (int k = 0; k < 7; k++)                        // fill the window and wrap it
            queue_sample(LUX_MAX, 1'b1, 32'd2000 + 32'(k) * 32'd600, 1'b0);
        queue_sample(20'd0, 1'b1, 32'hffff_ffff, 1'b0);    // time at the wrap point
        queue_sample(20'd0, 1'b1, 32'h0000_01f3, 1'b0);    // elapsed across the wrap
        queue_sample(20'd0, 1'b1, 32'h0000_2000, 1'b1);
        queue_sample(LUX_MAX, 1'b0, 32'hffff_ffff, 1'b1);  // invalid, all other bits set
        queue_sample(20'h5a5a5, 1'b1, 32'haaaa_aaaa, 1'b0);
        queue_sample(20'ha5a5a, 1'b1, 32'h5555_5555, 1'b0);
        queue_random_phase(100);
        wait_drained();

        // zero threshold and zero cooldown; receiver holds off once
        set_config(7'd0, 16'd0);
        long_holds_asked = long_holds_asked + 1;
        queue_random_phase(130);
        wait_drained();

        // largest meaningful threshold, longest cooldown
        set_config(7'd100, 16'hffff);
        queue_random_phase(120);
        wait_drained();

        // threshold beyond 100 %, 1 ms cooldown
        set_config(7'h7f, 16'd1);
        queue_random_phase(110);
        wait_drained();

        // random moderate settings, second long hold-off
        set_config(7'($urandom_range(1, 30)), 16'($urandom_range(0, 1000)));
        long_holds_asked = long_holds_asked + 1;
        queue_random_phase(130);
        wait_drained();

        set_config(7'($urandom_range(0, 127)), 16'($urandom()));
        queue_random_phase(120);
        wait_drained();

        // let any stray result show up before the verdict
        repeat (LAT_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && expected_levels.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
